/* rtl/qad_pkg.sv */
// qad_pkg: shared types, character codes and hex digit conversion for the
// query argument decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qad_pkg;

  typedef enum logic [1:0] {
    KIND_NAME_BYTE  = 2'd0,
    KIND_NAME_END   = 2'd1,
    KIND_VALUE_BYTE = 2'd2,
    KIND_VALUE_END  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_HIGH = 2'd2
  } esc_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CASE_MASK = 8'hDF;
  localparam logic [7:0] HEX_TEN   = 8'd10;

  // Unchecked conversion, modulo 256; the full byte feeds the low digit add.
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    if (c >= CH_UPA) begin
      d = (c & CASE_MASK) - CH_UPA + HEX_TEN;
    end else begin
      d = c - CH_ZERO;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

/* rtl/query_argument_decoder_core.sv */
// query_argument_decoder_core: top level, byte-serial form-query decoder.
// Depends on qad_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Takes one query-string character per cycle while in_stall is low and gives
// at most one registered result per character. Name bytes pass through, '='
// gives a name end, value bytes are decoded ('+' to space, '%'hh to a byte)
// and a zero byte, or '&' within a value, gives a value end. The decode is a single
// registered pass; a two-entry output buffer (result register plus skid
// register) lets a new character be accepted every cycle, and in_stall
// rises only once both entries hold results the receiver has not taken.
module query_argument_decoder_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [7:0]           in_byte,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [7:0]                out_byte,
  output qad_pkg::kind_t            out_kind
);
  import qad_pkg::*;

  logic       in_value_r, in_value_nxt;
  esc_t       esc_r, esc_nxt;
  logic [3:0] high_r, high_nxt;
  logic [7:0] digit;

  logic       res_valid;
  logic [7:0] res_byte;
  kind_t      res_kind;

  logic       main_valid_r, skid_valid_r;
  logic [7:0] main_byte_r, skid_byte_r;
  kind_t      main_kind_r, skid_kind_r;

  logic accept, push, pop;

  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && res_valid;
  assign pop      = main_valid_r && !out_stall;
  assign digit    = hex_digit(in_byte);

  // next state
  always_comb begin
    in_value_nxt = in_value_r;
    esc_nxt      = esc_r;
    high_nxt     = high_r;
    if (!in_value_r) begin
      esc_nxt = ESC_NONE;
      if (in_byte == CH_EQ) begin
        in_value_nxt = 1'b1;
      end
    end else if (in_byte == CH_NUL || in_byte == CH_AMP) begin
      in_value_nxt = 1'b0;
      esc_nxt      = ESC_NONE;
    end else begin
      unique case (esc_r)
        ESC_PCT: begin
          high_nxt = digit[3:0];
          esc_nxt  = ESC_HIGH;
        end
        ESC_HIGH: esc_nxt = ESC_NONE;
        default:  esc_nxt = (in_byte == CH_PCT) ? ESC_PCT : ESC_NONE;
      endcase
    end
  end

  // result of the current character
  always_comb begin
    res_valid = 1'b1;
    res_byte  = in_byte;
    res_kind  = KIND_VALUE_BYTE;
    if (!in_value_r) begin
      if (in_byte == CH_NUL) begin
        res_kind = KIND_VALUE_END;
      end else if (in_byte == CH_EQ) begin
        res_byte = CH_NUL;
        res_kind = KIND_NAME_END;
      end else begin
        res_kind = KIND_NAME_BYTE;
      end
    end else if (in_byte == CH_NUL || in_byte == CH_AMP) begin
      res_byte = CH_NUL;
      res_kind = KIND_VALUE_END;
    end else begin
      unique case (esc_r)
        ESC_PCT:  res_valid = 1'b0;
        ESC_HIGH: res_byte  = {high_r, 4'b0000} + digit;
        default: begin
          if (in_byte == CH_PCT) begin
            res_valid = 1'b0;
          end else if (in_byte == CH_PLUS) begin
            res_byte = CH_SPACE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_value_r <= 1'b0;
      esc_r      <= ESC_NONE;
      high_r     <= 4'd0;
    end else if (accept) begin
      in_value_r <= in_value_nxt;
      esc_r      <= esc_nxt;
      high_r     <= high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_byte_r <= skid_byte_r;
        main_kind_r <= skid_kind_r;
      end else if (push) begin
        main_byte_r <= res_byte;
        main_kind_r <= res_kind;
      end
    end else if (push) begin
      skid_byte_r <= res_byte;
      skid_kind_r <= res_kind;
    end
  end

  assign out_valid = main_valid_r;
  assign out_byte  = main_byte_r;
  assign out_kind  = main_kind_r;

endmodule

`default_nettype wire

/* rtl/qad_checker.sv */
// qad_checker: port-level assertions for query_argument_decoder_core,
// bound to the top level. Depends on qad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qad_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire logic [7:0]     out_byte,
  input wire qad_pkg::kind_t out_kind
);
  import qad_pkg::*;

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("buffer not empty after reset");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NAME_END || out_kind == KIND_VALUE_END)
      |-> out_byte == CH_NUL)
    else $error("end marker with nonzero byte");

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted request");

  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output backpressure");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("stalled result changed");

endmodule

bind query_argument_decoder_core qad_checker u_qad_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .out_kind  (out_kind)
);

`default_nettype wire
